[rtl/imadec_pkg.sv]
// shared types, constants and tables for the ima adpcm nibble decoder
`timescale 1ns / 1ps
`default_nettype none

package imadec_pkg;

    localparam int DEF_NUM_CHANNELS = 2;

    localparam int POS_W    = 7;
    localparam int SAMPLE_W = 16;
    localparam int STEP_W   = 15;
    localparam int CODE_W   = 4;

    localparam logic [POS_W-1:0] MAX_POS = 7'd88;

    // wide accumulator limits for the saturating add
    localparam logic signed [17:0] ACC_MAX = 18'sd32767;
    localparam logic signed [17:0] ACC_MIN = -18'sd32768;

    // per-channel predictor state
    typedef struct packed {
        logic [POS_W-1:0]           pos;
        logic signed [SAMPLE_W-1:0] sample;
    } t_pred_state;

    // step index adjustment from the three magnitude bits
    function automatic logic signed [4:0] pos_delta(input logic [2:0] mag);
        logic signed [4:0] d;
        case (mag)
            3'd4:    d = 5'sd2;
            3'd5:    d = 5'sd4;
            3'd6:    d = 5'sd6;
            3'd7:    d = 5'sd8;
            default: d = -5'sd1;
        endcase
        return d;
    endfunction

    // quantizer step size table, 89 entries
    function automatic logic [STEP_W-1:0] step_size(input logic [POS_W-1:0] pos);
        logic [STEP_W-1:0] s;
        case (pos)
            7'd0:  s = 15'd7;      7'd1:  s = 15'd8;      7'd2:  s = 15'd9;
            7'd3:  s = 15'd10;     7'd4:  s = 15'd11;     7'd5:  s = 15'd12;
            7'd6:  s = 15'd13;     7'd7:  s = 15'd14;     7'd8:  s = 15'd16;
            7'd9:  s = 15'd17;     7'd10: s = 15'd19;     7'd11: s = 15'd21;
            7'd12: s = 15'd23;     7'd13: s = 15'd25;     7'd14: s = 15'd28;
            7'd15: s = 15'd31;     7'd16: s = 15'd34;     7'd17: s = 15'd37;
            7'd18: s = 15'd41;     7'd19: s = 15'd45;     7'd20: s = 15'd50;
            7'd21: s = 15'd55;     7'd22: s = 15'd60;     7'd23: s = 15'd66;
            7'd24: s = 15'd73;     7'd25: s = 15'd80;     7'd26: s = 15'd88;
            7'd27: s = 15'd97;     7'd28: s = 15'd107;    7'd29: s = 15'd118;
            7'd30: s = 15'd130;    7'd31: s = 15'd143;    7'd32: s = 15'd157;
            7'd33: s = 15'd173;    7'd34: s = 15'd190;    7'd35: s = 15'd209;
            7'd36: s = 15'd230;    7'd37: s = 15'd253;    7'd38: s = 15'd279;
            7'd39: s = 15'd307;    7'd40: s = 15'd337;    7'd41: s = 15'd371;
            7'd42: s = 15'd408;    7'd43: s = 15'd449;    7'd44: s = 15'd494;
            7'd45: s = 15'd544;    7'd46: s = 15'd598;    7'd47: s = 15'd658;
            7'd48: s = 15'd724;    7'd49: s = 15'd796;    7'd50: s = 15'd876;
            7'd51: s = 15'd963;    7'd52: s = 15'd1060;   7'd53: s = 15'd1166;
            7'd54: s = 15'd1282;   7'd55: s = 15'd1411;   7'd56: s = 15'd1552;
            7'd57: s = 15'd1707;   7'd58: s = 15'd1878;   7'd59: s = 15'd2066;
            7'd60: s = 15'd2272;   7'd61: s = 15'd2499;   7'd62: s = 15'd2749;
            7'd63: s = 15'd3024;   7'd64: s = 15'd3327;   7'd65: s = 15'd3660;
            7'd66: s = 15'd4026;   7'd67: s = 15'd4428;   7'd68: s = 15'd4871;
            7'd69: s = 15'd5358;   7'd70: s = 15'd5894;   7'd71: s = 15'd6484;
            7'd72: s = 15'd7132;   7'd73: s = 15'd7845;   7'd74: s = 15'd8630;
            7'd75: s = 15'd9493;   7'd76: s = 15'd10442;  7'd77: s = 15'd11487;
            7'd78: s = 15'd12635;  7'd79: s = 15'd13899;  7'd80: s = 15'd15289;
            7'd81: s = 15'd16818;  7'd82: s = 15'd18500;  7'd83: s = 15'd20350;
            7'd84: s = 15'd22385;  7'd85: s = 15'd24623;  7'd86: s = 15'd27086;
            7'd87: s = 15'd29794;
            default: s = 15'd32767;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

[rtl/imadec_nibble.sv]
// one adpcm code step: table lookup, scaled difference, saturating add, step index update
`timescale 1ns / 1ps
`default_nettype none

module imadec_nibble
    import imadec_pkg::*;
(
    input  wire logic [CODE_W-1:0] i_code,
    input  wire t_pred_state       i_state,
    output t_pred_state            o_state
);

    logic [POS_W-1:0]           w_pos;
    logic [STEP_W-1:0]          w_step;
    logic [18:0]                w_prod;
    logic [15:0]                w_diff;
    logic signed [17:0]         w_acc;
    logic signed [8:0]          w_next;
    logic signed [4:0]          w_delta;
    logic signed [SAMPLE_W-1:0] w_sample;
    logic [POS_W-1:0]           w_pos_new;

    // positions above the table read as the last entry
    assign w_pos   = (i_state.pos > MAX_POS) ? MAX_POS : i_state.pos;
    assign w_step  = step_size(w_pos);
    assign w_delta = pos_delta(i_code[2:0]);

    // (2*mag+1)*step, then divide by 8
    assign w_prod = 19'({i_code[2:0], 1'b1}) * 19'(w_step);
    assign w_diff = w_prod[18:3];

    always_comb begin
        if (i_code[3]) begin
            w_acc = 18'(i_state.sample) - $signed({2'b00, w_diff});
        end else begin
            w_acc = 18'(i_state.sample) + $signed({2'b00, w_diff});
        end
        if (w_acc > ACC_MAX) begin
            w_sample = ACC_MAX[SAMPLE_W-1:0];
        end else if (w_acc < ACC_MIN) begin
            w_sample = ACC_MIN[SAMPLE_W-1:0];
        end else begin
            w_sample = w_acc[SAMPLE_W-1:0];
        end
    end

    assign w_next = $signed({2'b00, w_pos}) + {{4{w_delta[4]}}, w_delta};

    always_comb begin
        if (w_next < 9'sd0) begin
            w_pos_new = '0;
        end else if (w_next > $signed({2'b00, MAX_POS})) begin
            w_pos_new = MAX_POS;
        end else begin
            w_pos_new = w_next[POS_W-1:0];
        end
    end

    assign o_state = {w_pos_new, w_sample};

endmodule

`default_nettype wire

[rtl/ima_adpcm_nibble_decoder.sv]
// top level of the ima adpcm nibble decoder, two codes per byte, per-channel state
// usage:
//  - slave stream: s_axis_tdata carries one byte with two 4-bit codes, the low
//    nibble decoded first; s_axis_tuser carries the channel select and the
//    restart flag, which zeroes that channel's step index and prediction first
//  - master stream: m_axis_tdata carries the two signed 16-bit samples, first
//    in the low half; m_axis_tuser carries the channel they belong to
//  - pipeline: an accepted transfer is held in the input register; when the
//    result register is free, both nibbles are decoded from the input register
//    and loaded into the result register, which drives the master stream
//  - throughput: one byte per cycle while m_axis_tready is high, also on the same
//    channel back to back; the predictor state is read and written in the decode cycle
//  - stall: the result register holds while m_axis_tready is low, the input
//    register fills behind it, then s_axis_tready drops; nothing is lost
//  - reset clears both pipeline valids and every channel's state to zero
//  - a channel select at or above the channel count wraps modulo the count
`timescale 1ns / 1ps
`default_nettype none

module ima_adpcm_nibble_decoder
    import imadec_pkg::*;
#(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] code_byte
    input  wire logic [1:0]  s_axis_tuser,   // [0] channel, [1] restart
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [15:0] first_sample, [31:16] second_sample
    output logic [0:0]       m_axis_tuser    // [0] out_channel
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_chan;
    logic        r_in_restart;

    // result register
    logic        r_out_valid;
    logic [31:0] r_out_data;
    logic        r_out_chan;

    // per-channel predictor state
    logic [POS_W-1:0]           r_pos  [NUM_CHANNELS];
    logic signed [SAMPLE_W-1:0] r_pred [NUM_CHANNELS];

    logic        w_out_load;
    logic        w_decode;
    logic        w_chan;
    logic [CH_W-1:0] w_idx;
    t_pred_state w_start;
    t_pred_state w_mid;
    t_pred_state w_end;

    // result register frees up when empty or being taken
    assign w_out_load    = !r_out_valid || m_axis_tready;
    assign w_decode      = r_in_valid && w_out_load;
    assign s_axis_tready = !r_in_valid || w_out_load;

    // channel wraps modulo the channel count
    assign w_chan = (NUM_CHANNELS > 1) ? r_in_chan : 1'b0;
    assign w_idx  = CH_W'(w_chan);

    // restart zeroes the state before the first nibble
    always_comb begin
        if (r_in_restart) begin
            w_start = '0;
        end else begin
            w_start.pos    = r_pos[w_idx];
            w_start.sample = r_pred[w_idx];
        end
    end

    imadec_nibble u_low (
        .i_code  (r_in_byte[3:0]),
        .i_state (w_start),
        .o_state (w_mid)
    );

    imadec_nibble u_high (
        .i_code  (r_in_byte[7:4]),
        .i_state (w_mid),
        .o_state (w_end)
    );

    // control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_pos[i]  <= '0;
                r_pred[i] <= '0;
            end
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_out_load) begin
                r_out_valid <= r_in_valid;
            end
            if (w_decode) begin
                r_pos[w_idx]  <= w_end.pos;
                r_pred[w_idx] <= w_end.sample;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte    <= s_axis_tdata;
            r_in_chan    <= s_axis_tuser[0];
            r_in_restart <= s_axis_tuser[1];
        end
        if (w_decode) begin
            r_out_data <= {w_end.sample, w_mid.sample};
            r_out_chan <= w_chan;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tuser[0] = r_out_chan;

endmodule

`default_nettype wire
